@@ hdl/mccs_pkg.sv @@
// ----------------------------------------------------------------------------
// mccs_pkg: shared types and constants of the moisture channel conditioner
// Word layouts of the sample and result channels, register indexes, result
// kinds and the sequencer states.
// ----------------------------------------------------------------------------
package mccs_pkg;

    // Field widths.
    localparam int SAMPLE_W   = 10;
    localparam int BOUND_W    = 11;
    localparam int CNT_W      = 16;
    localparam int GRAPH_W    = 8;
    localparam int STATUS_W   = 2;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // Tracker start value on a calibration restart, and the reset air bound.
    localparam int SAMPLE_BITS = 10;
    localparam logic [BOUND_W-1:0] CAL_MIN_INIT = BOUND_W'(1 << SAMPLE_BITS);
    localparam logic [SAMPLE_W-1:0] AIR_INIT = '1;

    // Quotient bits produced by the serial divider.
    localparam int QUO_W   = 8;
    localparam int QCNT_W  = $clog2(QUO_W);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RUNNING     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIG_MENU = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CALIBRATING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AIR_VALUE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WATER_VALUE = 3'd4;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GRAPH   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CAL     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_MOTOR   = 2'd3;

    // Input request types.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_MOTOR  = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [SAMPLE_W-1:0] sample_value;
        logic [STATUS_W-1:0] sample_status;
        logic                sample_valid;
        logic                motor_on;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]   result_kind;
        logic [GRAPH_W-1:0]  graph_value;
        logic                graph_motor;
        logic [STATUS_W-1:0] graph_status;
        logic [SAMPLE_W-1:0] clamped_value;
        logic [SAMPLE_W-1:0] air_bound;
        logic [BOUND_W-1:0]  water_bound;
        logic                bounds_dirty;
        logic [CNT_W-1:0]    error_count;
        logic [CNT_W-1:0]    reading_count;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHK,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

@@ hdl/moisture_channel_calibrate_scale.sv @@
// ----------------------------------------------------------------------------
// moisture_channel_calibrate_scale: soil moisture sample conditioner
// Tracks calibration bounds, clamps each sample, scales it to a graph point
// with a bit-serial divider and keeps saturating reading and error counters.
// ----------------------------------------------------------------------------
// One word in gives one word out. A motor event, a menu sample or a sample
// while stopped passes from the accept cycle through the DONE state to the
// output register. A graph point passes through the MUL, CHK, DIV and DONE
// states. Tracking and clamping settle in the accept cycle. MUL multiplies by
// GRAPH_MAX, CHK checks for overflow and DIV runs the restoring divider, which
// produces one quotient bit per cycle. DONE loads the output register once it
// is free. A new word is taken as soon as the previous one has moved to the
// output register, even if that result still waits for m_ready. Configuration
// writes are taken at any time (cfg_ready is always high) and must only be
// issued while idle.
module moisture_channel_calibrate_scale #(
    parameter int GRAPH_MAX = 255
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // sample / motor event channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  mccs_pkg::in_item_t                  s_data,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output mccs_pkg::out_item_t                 m_data,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mccs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mccs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mccs_pkg::*;

    // Scaling widths follow from GRAPH_MAX.
    localparam int GM_W  = $clog2(GRAPH_MAX + 1);
    localparam int NUM_W = SAMPLE_W + GM_W;
    localparam int CMP_W = (NUM_W > BOUND_W + QUO_W) ? NUM_W : BOUND_W + QUO_W;
    localparam logic [GM_W-1:0] GM_VAL = GM_W'(GRAPH_MAX);

    // ------------------------------------------------------------------
    // Channel state
    // ------------------------------------------------------------------
    logic                running_reg,       running_next;
    logic                menu_reg,          menu_next;
    logic                calibrating_reg,   calibrating_next;
    logic [BOUND_W-1:0]  cal_min_reg,       cal_min_next;
    logic [SAMPLE_W-1:0] cal_max_reg,       cal_max_next;
    logic [SAMPLE_W-1:0] air_work_reg,      air_work_next;
    logic [BOUND_W-1:0]  water_work_reg,    water_work_next;
    logic [SAMPLE_W-1:0] level_reg,         level_next;
    logic                motor_now_reg,     motor_now_next;
    logic                motor_pending_reg, motor_pending_next;
    logic                dirty_reg,         dirty_next;
    logic [CNT_W-1:0]    invalid_cnt_reg,   invalid_cnt_next;
    logic [CNT_W-1:0]    sample_cnt_reg,    sample_cnt_next;

    // Sequencer and serial scaling datapath.
    state_t              state_reg, state_next;
    logic [QCNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [SAMPLE_W-1:0] xmag_reg;      // |clamped - air|
    logic                xneg_reg;
    logic [BOUND_W-1:0]  dmag_reg;      // |water - air|
    logic                dneg_reg;
    logic                dzero_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [BOUND_W-1:0]  rem_reg;
    logic [QUO_W-1:0]    lo_reg;        // dividend low bits, then quotient
    logic                ovf_reg;
    out_item_t           hold_reg;      // result fields waiting on the divider

    // Output register.
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_data_reg;

    // ------------------------------------------------------------------
    // Handshake decode
    // ------------------------------------------------------------------
    logic in_fire;
    logic cfg_fire;
    logic out_load;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Per-sample front end: tracking, clamping and scaling operands
    // ------------------------------------------------------------------
    logic                is_graph;
    logic [KIND_W-1:0]   kind;
    logic [BOUND_W-1:0]  trk_min;
    logic [SAMPLE_W-1:0] trk_max;
    logic [SAMPLE_W-1:0] air_eff;
    logic [BOUND_W-1:0]  water_eff;
    logic                bounds_moved;
    logic [SAMPLE_W-1:0] clamped;
    logic                x_neg;
    logic [SAMPLE_W-1:0] x_mag;
    logic                d_neg;
    logic [BOUND_W-1:0]  d_mag;
    logic [BOUND_W-1:0]  smp_ext;
    logic [BOUND_W-1:0]  air_ext;

    always_comb begin
        smp_ext = {1'b0, s_data.sample_value};

        if (s_data.req_type == REQ_MOTOR) begin
            kind = KIND_MOTOR;
        end else if (menu_reg) begin
            kind = KIND_CAL;
        end else if (running_reg) begin
            kind = KIND_GRAPH;
        end else begin
            kind = KIND_IGNORED;
        end
        is_graph = (kind == KIND_GRAPH);

        // Trackers widen the bounds to the sample while calibrating.
        trk_min = (smp_ext < cal_min_reg) ? smp_ext : cal_min_reg;
        trk_max = (s_data.sample_value > cal_max_reg) ? s_data.sample_value : cal_max_reg;
        air_eff   = calibrating_reg ? trk_max : air_work_reg;
        water_eff = calibrating_reg ? trk_min : water_work_reg;
        bounds_moved = calibrating_reg &&
                       ((air_work_reg != trk_max) || (water_work_reg != trk_min));

        // Water bound is tested first; inverted bounds pick one of the two.
        if (smp_ext < water_eff) begin
            clamped = water_eff[SAMPLE_W-1:0];
        end else if (s_data.sample_value > air_eff) begin
            clamped = air_eff;
        end else begin
            clamped = s_data.sample_value;
        end

        air_ext = {1'b0, air_eff};
        x_neg = (clamped < air_eff);
        x_mag = x_neg ? (air_eff - clamped) : (clamped - air_eff);
        d_neg = (water_eff < air_ext);
        d_mag = d_neg ? (air_ext - water_eff) : (water_eff - air_ext);
    end

    // ------------------------------------------------------------------
    // State next values: configuration writes, then accepted words
    // ------------------------------------------------------------------
    always_comb begin
        running_next       = running_reg;
        menu_next          = menu_reg;
        calibrating_next   = calibrating_reg;
        cal_min_next       = cal_min_reg;
        cal_max_next       = cal_max_reg;
        air_work_next      = air_work_reg;
        water_work_next    = water_work_reg;
        level_next         = level_reg;
        motor_now_next     = motor_now_reg;
        motor_pending_next = motor_pending_reg;
        dirty_next         = dirty_reg;
        invalid_cnt_next   = invalid_cnt_reg;
        sample_cnt_next    = sample_cnt_reg;

        if (cfg_fire) begin
            case (cfg_index)
                REG_RUNNING: begin
                    // A change of the run state restarts the error count.
                    if (cfg_data[0] != running_reg) begin
                        invalid_cnt_next = '0;
                    end
                    running_next = cfg_data[0];
                    dirty_next   = 1'b0;
                end
                REG_CONFIG_MENU: begin
                    menu_next  = cfg_data[0];
                    dirty_next = 1'b0;
                end
                REG_CALIBRATING: begin
                    calibrating_next = cfg_data[0];
                    if (cfg_data[0]) begin
                        cal_min_next = CAL_MIN_INIT;
                        cal_max_next = '0;
                    end
                    dirty_next = 1'b0;
                end
                REG_AIR_VALUE: begin
                    air_work_next = cfg_data[SAMPLE_W-1:0];
                    dirty_next    = 1'b0;
                end
                REG_WATER_VALUE: begin
                    water_work_next = {1'b0, cfg_data[SAMPLE_W-1:0]};
                    dirty_next      = 1'b0;
                end
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end else if (in_fire) begin
            if (kind == KIND_MOTOR) begin
                motor_now_next = s_data.motor_on;
                if (s_data.motor_on) begin
                    motor_pending_next = 1'b1;
                end
            end else if (is_graph) begin
                if (sample_cnt_reg != '1) begin
                    sample_cnt_next = sample_cnt_reg + 1'b1;
                end
                if (calibrating_reg) begin
                    cal_min_next    = trk_min;
                    cal_max_next    = trk_max;
                    air_work_next   = trk_max;
                    water_work_next = trk_min;
                    if (bounds_moved) begin
                        dirty_next = 1'b1;
                    end
                end
                level_next         = clamped;
                motor_pending_next = 1'b0;
                if (!s_data.sample_valid && (invalid_cnt_reg != '1)) begin
                    invalid_cnt_next = invalid_cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg       <= 1'b0;
            menu_reg          <= 1'b0;
            calibrating_reg   <= 1'b0;
            cal_min_reg       <= CAL_MIN_INIT;
            cal_max_reg       <= '0;
            air_work_reg      <= AIR_INIT;
            water_work_reg    <= '0;
            level_reg         <= '0;
            motor_now_reg     <= 1'b0;
            motor_pending_reg <= 1'b0;
            dirty_reg         <= 1'b0;
            invalid_cnt_reg   <= '0;
            sample_cnt_reg    <= '0;
        end else begin
            running_reg       <= running_next;
            menu_reg          <= menu_next;
            calibrating_reg   <= calibrating_next;
            cal_min_reg       <= cal_min_next;
            cal_max_reg       <= cal_max_next;
            air_work_reg      <= air_work_next;
            water_work_reg    <= water_work_next;
            level_reg         <= level_next;
            motor_now_reg     <= motor_now_next;
            motor_pending_reg <= motor_pending_next;
            dirty_reg         <= dirty_next;
            invalid_cnt_reg   <= invalid_cnt_next;
            sample_cnt_reg    <= sample_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = is_graph ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL: begin
                state_next = ST_CHK;
            end
            ST_CHK: begin
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                // Advance one quotient bit a cycle; the counter wraps to zero.
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == QCNT_W'(QUO_W - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Serial scaling datapath
    // ------------------------------------------------------------------
    logic [BOUND_W:0]    div_trial;
    logic [BOUND_W:0]    div_diff;
    logic                div_ge;
    logic [CMP_W-1:0]    num_cmp;
    logic [CMP_W-1:0]    den_cmp;

    always_comb begin
        div_trial = {rem_reg, lo_reg[QUO_W-1]};
        div_ge    = (div_trial >= {1'b0, dmag_reg});
        div_diff  = div_trial - {1'b0, dmag_reg};
        num_cmp   = CMP_W'(num_reg);
        den_cmp   = CMP_W'(dmag_reg) << QUO_W;
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    // Capture operands and every field but the graph value.
                    xmag_reg  <= x_mag;
                    xneg_reg  <= x_neg;
                    dmag_reg  <= d_mag;
                    dneg_reg  <= d_neg;
                    dzero_reg <= (d_mag == '0);
                    hold_reg.result_kind   <= kind;
                    hold_reg.graph_value   <= '0;
                    hold_reg.graph_motor   <= is_graph && (motor_now_reg || motor_pending_reg);
                    hold_reg.graph_status  <= is_graph ? s_data.sample_status : '0;
                    hold_reg.clamped_value <= is_graph ? clamped : '0;
                    hold_reg.air_bound     <= air_work_next;
                    hold_reg.water_bound   <= water_work_next;
                    hold_reg.bounds_dirty  <= dirty_next;
                    hold_reg.error_count   <= invalid_cnt_next;
                    hold_reg.reading_count <= sample_cnt_next;
                end
            end
            ST_MUL: begin
                num_reg <= NUM_W'(xmag_reg) * NUM_W'(GM_VAL);
            end
            ST_CHK: begin
                // Quotient of 256 or more saturates; otherwise eight bits remain.
                ovf_reg <= (num_cmp >= den_cmp);
                rem_reg <= BOUND_W'(num_reg >> QUO_W);
                lo_reg  <= num_reg[QUO_W-1:0];
            end
            ST_DIV: begin
                rem_reg <= div_ge ? div_diff[BOUND_W-1:0] : div_trial[BOUND_W-1:0];
                lo_reg  <= {lo_reg[QUO_W-2:0], div_ge};
            end
            default: begin
                // hold
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result: sign, saturation and the output register
    // ------------------------------------------------------------------
    logic               q_neg;
    logic [GRAPH_W-1:0] graph_final;
    out_item_t          result_word;

    always_comb begin
        q_neg = xneg_reg ^ dneg_reg;
        if ((hold_reg.result_kind != KIND_GRAPH) || dzero_reg) begin
            graph_final = '0;
        end else if (q_neg && (ovf_reg || (lo_reg != '0))) begin
            graph_final = '0;           // negative quotient clips to zero
        end else if (ovf_reg) begin
            graph_final = '1;
        end else begin
            graph_final = lo_reg;
        end
        result_word             = hold_reg;
        result_word.graph_value = graph_final;
        m_valid_next = out_load || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= result_word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_graph_to_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && is_graph) |=> (state_reg == ST_MUL))
        else $error("graph sample did not start the scaler");

    a_div_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_DIV) |-> (div_cnt_reg == '0))
        else $error("divider count left nonzero outside the divide loop");

    a_water_range: assert property (@(posedge aclk) disable iff (!aresetn)
        water_work_reg <= CAL_MIN_INIT)
        else $error("water bound out of range");

    a_flat_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.result_kind == KIND_GRAPH) &&
         (m_data_reg.water_bound == {1'b0, m_data_reg.air_bound}))
        |-> (m_data_reg.graph_value == '0))
        else $error("equal bounds gave a nonzero graph value");

    a_nongraph_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_data_reg.result_kind != KIND_GRAPH))
        |-> ((m_data_reg.graph_value == '0) && (m_data_reg.clamped_value == '0)))
        else $error("non-graph result carries graph fields");

endmodule
